// ===== sv/assert_macros.svh =====
// -----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define IES_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define IES_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== sv/ies_pkg.sv =====
// -----------------------------------------------------------------------------
// ies_pkg
// Shared types, constants and codes of the icosphere edge subdivider
// -----------------------------------------------------------------------------
package ies_pkg;

	localparam int IDX_W      = 10;
	localparam int CNT_W      = 11;
	localparam int VTX_DEPTH  = 1024;
	localparam int EDGE_DEPTH = 1024;
	localparam int COORD_W    = 16;
	localparam int SUM_W      = 18;
	localparam int MAG_W      = 17;
	localparam int RAD_W      = 15;
	localparam int NN_W       = 2 * MAG_W;
	localparam int WORK_W     = 62;
	localparam int ROOT_LAST  = 30;
	localparam int QUO_W      = 17;
	localparam int FRAC_W     = 14;

	localparam logic [RAD_W-1:0] RAD_RESET = RAD_W'(16384);

	// item kinds
	localparam logic [1:0] KIND_LOAD   = 2'd0;
	localparam logic [1:0] KIND_SUBDIV = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	typedef struct packed {
		logic [1:0]                kind;
		logic [IDX_W-1:0]          first_corner;
		logic [IDX_W-1:0]          second_corner;
		logic [IDX_W-1:0]          third_corner;
		logic signed [COORD_W-1:0] load_x;
		logic signed [COORD_W-1:0] load_y;
		logic signed [COORD_W-1:0] load_z;
	} ies_in_t;

	typedef struct packed {
		logic                      item_type;
		logic [IDX_W-1:0]          index_a;
		logic [IDX_W-1:0]          index_b;
		logic [IDX_W-1:0]          index_c;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic                      store_full;
		logic                      last;
	} ies_out_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} ies_vtx_t;

	typedef struct packed {
		logic [IDX_W-1:0] lo;
		logic [IDX_W-1:0] hi;
		logic [IDX_W-1:0] vid;
	} ies_edge_t;

	typedef struct packed {
		logic start;
		logic insert;
		logic clear;
	} ies_et_cmd_t;

	typedef struct packed {
		logic done;
		logic hit;
		logic full;
	} ies_et_stat_t;

	typedef enum logic [2:0] {
		N_IDLE,
		N_SQUARE,
		N_ROOT,
		N_SCALE,
		N_PREP,
		N_DIVIDE,
		N_DONE
	} ies_norm_st_t;

	typedef enum logic [3:0] {
		T_IDLE,
		T_LOAD,
		T_SEARCH_GO,
		T_SEARCH_WAIT,
		T_RD_P,
		T_RD_Q,
		T_RD_W,
		T_NORM_GO,
		T_NORM_WAIT,
		T_VTX,
		T_ERR,
		T_TRI
	} ies_top_st_t;

endpackage

// ===== sv/ies_norm_unit.sv =====
// -----------------------------------------------------------------------------
// ies_norm_unit
// Turns a corner sum into a point on the sphere: squares, integer root and
// one restoring divide per coordinate, all on one shared datapath
// -----------------------------------------------------------------------------
module ies_norm_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [ies_pkg::SUM_W-1:0]   sum_x,
	input  logic signed [ies_pkg::SUM_W-1:0]   sum_y,
	input  logic signed [ies_pkg::SUM_W-1:0]   sum_z,
	input  logic [ies_pkg::RAD_W-1:0]          radius,
	output logic                               done,
	output logic signed [ies_pkg::COORD_W-1:0] pos_x,
	output logic signed [ies_pkg::COORD_W-1:0] pos_y,
	output logic signed [ies_pkg::COORD_W-1:0] pos_z
);
	import ies_pkg::*;

	ies_norm_st_t st_q, st_d;

	logic [MAG_W-1:0]          mag_q [3];
	logic                      neg_q [3];
	logic [RAD_W-1:0]          rad_q;
	logic [1:0]                crd_q;
	logic [4:0]                cnt_q;
	logic [NN_W-1:0]           prod_q;
	logic [NN_W-1:0]           nn_q;
	logic [WORK_W-1:0]         rem_q;
	logic [WORK_W-1:0]         res_q;
	logic [QUO_W-1:0]          quo_q;
	logic signed [COORD_W-1:0] pos_q [3];

	logic [1:0]          sel;
	logic [MAG_W-1:0]    mul_a, mul_b;
	logic [NN_W-1:0]     mul_p;
	logic [NN_W-1:0]     nn_next;
	logic [WORK_W-1:0]   bit_v, trial, div_trial;
	logic [WORK_W-1:0]   n_v;
	logic                ge;
	logic [QUO_W-1:0]    q_next;
	logic signed [COORD_W-1:0] coord;

	// shared multiplier: squares first, then magnitude times radius
	assign sel   = (crd_q == 2'd3) ? 2'd2 : crd_q;
	assign mul_a = mag_q[sel];
	assign mul_b = (st_q == N_SQUARE) ? mag_q[sel] : MAG_W'(rad_q);
	assign mul_p = mul_a * mul_b;

	assign nn_next = nn_q + prod_q;

	// root step and divide step share the wide compare
	assign bit_v     = WORK_W'(1) << {cnt_q, 1'b0};
	assign n_v       = WORK_W'(res_q[ROOT_LAST:0]);
	assign div_trial = WORK_W'({res_q[ROOT_LAST:0], 1'b0}) << cnt_q;
	assign trial     = (st_q == N_ROOT) ? (res_q + bit_v) : div_trial;
	assign ge        = rem_q >= trial;
	assign q_next    = {quo_q[QUO_W-2:0], ge};

	// saturate and apply sign
	always_comb begin
		if (neg_q[sel]) begin
			if (q_next > QUO_W'(32768))
				coord = -16'sd32768;
			else
				coord = -$signed(COORD_W'(q_next));
		end else begin
			if (q_next > QUO_W'(32767))
				coord = 16'sd32767;
			else
				coord = $signed(COORD_W'(q_next));
		end
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			N_IDLE:   if (start) st_d = N_SQUARE;
			N_SQUARE: begin
				if (crd_q == 2'd3)
					st_d = (nn_next == '0) ? N_DONE : N_ROOT;
			end
			N_ROOT:   if (cnt_q == '0) st_d = N_SCALE;
			N_SCALE:  st_d = N_PREP;
			N_PREP:   st_d = N_DIVIDE;
			N_DIVIDE: begin
				if (cnt_q == '0)
					st_d = (crd_q == 2'd2) ? N_DONE : N_SCALE;
			end
			N_DONE:   st_d = N_IDLE;
			default:  st_d = N_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		done = (st_q == N_DONE);
	end

	assign pos_x = pos_q[0];
	assign pos_y = pos_q[1];
	assign pos_z = pos_q[2];

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= N_IDLE;
			crd_q <= '0;
			cnt_q <= '0;
		end else begin
			st_q <= st_d;
			unique case (st_q)
				N_IDLE: begin
					crd_q <= '0;
				end
				N_SQUARE: begin
					if (crd_q == 2'd3) begin
						crd_q <= '0;
						cnt_q <= 5'(ROOT_LAST);
					end else begin
						crd_q <= crd_q + 2'd1;
					end
				end
				N_ROOT: begin
					if (cnt_q != '0)
						cnt_q <= cnt_q - 5'd1;
				end
				N_PREP: begin
					cnt_q <= 5'(QUO_W - 1);
				end
				N_DIVIDE: begin
					if (cnt_q == '0)
						crd_q <= crd_q + 2'd1;
					else
						cnt_q <= cnt_q - 5'd1;
				end
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (st_q)
			N_IDLE: begin
				if (start) begin
					neg_q[0] <= sum_x[SUM_W-1];
					neg_q[1] <= sum_y[SUM_W-1];
					neg_q[2] <= sum_z[SUM_W-1];
					mag_q[0] <= MAG_W'(sum_x[SUM_W-1] ? -sum_x : sum_x);
					mag_q[1] <= MAG_W'(sum_y[SUM_W-1] ? -sum_y : sum_y);
					mag_q[2] <= MAG_W'(sum_z[SUM_W-1] ? -sum_z : sum_z);
					rad_q    <= radius;
					nn_q     <= '0;
				end
			end
			N_SQUARE: begin
				if (crd_q != 2'd0)
					nn_q <= nn_next;
				if (crd_q != 2'd3)
					prod_q <= mul_p;
				else begin
					rem_q <= {nn_next[NN_W-1:0], 28'd0};
					res_q <= '0;
					if (nn_next == '0) begin
						pos_q[0] <= '0;
						pos_q[1] <= '0;
						pos_q[2] <= '0;
					end
				end
			end
			N_ROOT: begin
				if (ge) begin
					rem_q <= rem_q - trial;
					res_q <= (res_q >> 1) + bit_v;
				end else begin
					res_q <= res_q >> 1;
				end
			end
			N_SCALE: begin
				prod_q <= mul_p;
			end
			N_PREP: begin
				// dividend is twice the scaled magnitude plus n, for round half up
				rem_q <= WORK_W'({prod_q[2*FRAC_W+3:0], 15'd0}) + n_v;
				quo_q <= '0;
			end
			N_DIVIDE: begin
				if (ge)
					rem_q <= rem_q - trial;
				quo_q <= q_next;
				if (cnt_q == '0)
					pos_q[sel] <= coord;
			end
			default: ;
		endcase
	end

endmodule

// ===== sv/ies_edge_tab.sv =====
// -----------------------------------------------------------------------------
// ies_edge_tab
// Edge table: filled in order, searched one entry a cycle up to the fill count
// -----------------------------------------------------------------------------
module ies_edge_tab (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ies_pkg::ies_et_cmd_t         cmd,
	input  logic [ies_pkg::IDX_W-1:0]    key_lo,
	input  logic [ies_pkg::IDX_W-1:0]    key_hi,
	input  logic [ies_pkg::IDX_W-1:0]    ins_vid,
	output ies_pkg::ies_et_stat_t        stat,
	output logic [ies_pkg::IDX_W-1:0]    vid
);
	import ies_pkg::*;

	ies_edge_t        mem [EDGE_DEPTH];
	ies_edge_t        rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] ptr_q;
	logic             busy_q;
	logic             rdv_q;
	logic             done_q;
	logic             hit_q;
	logic [IDX_W-1:0] vid_q;

	logic match, issue;

	assign match = busy_q && rdv_q && (rd_q.lo == key_lo) && (rd_q.hi == key_hi);
	assign issue = busy_q && !match && (ptr_q != cnt_q);

	// table storage, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.insert)
			mem[cnt_q[IDX_W-1:0]] <= '{lo: key_lo, hi: key_hi, vid: ins_vid};
		rd_q <= mem[ptr_q[IDX_W-1:0]];
	end

	// scan control and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			ptr_q  <= '0;
			busy_q <= 1'b0;
			rdv_q  <= 1'b0;
			done_q <= 1'b0;
			hit_q  <= 1'b0;
			vid_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.clear) begin
				cnt_q  <= '0;
				busy_q <= 1'b0;
				rdv_q  <= 1'b0;
			end else begin
				if (cmd.start) begin
					busy_q <= 1'b1;
					ptr_q  <= '0;
					rdv_q  <= 1'b0;
				end else if (busy_q) begin
					rdv_q <= issue;
					if (issue)
						ptr_q <= ptr_q + CNT_W'(1);
					if (match) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
						hit_q  <= 1'b1;
						vid_q  <= rd_q.vid;
					end else if (!rdv_q && ptr_q == cnt_q) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
						hit_q  <= 1'b0;
					end
				end
				if (cmd.insert)
					cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	assign stat.done = done_q;
	assign stat.hit  = hit_q;
	assign stat.full = (cnt_q == CNT_W'(EDGE_DEPTH));
	assign vid       = vid_q;

endmodule

// ===== sv/icosphere_edge_subdivider.sv =====
// Load item: its result is registered once the output register is free.
// Subdivide item: each edge probe scans the edge table at one entry a cycle,
// up to the fill count; each new vertex is then made in the normalise unit
// (31 root steps, then a scale and a divide per coordinate). Triangles follow one
// a cycle unless the output stalls. One item at a time; ready only between items.
// Reset: asynchronous, clears counts, radius to 1.0; store contents are kept.
// -----------------------------------------------------------------------------
// icosphere_edge_subdivider
// Splits a sphere triangle into four, sharing edge midpoints via an edge table
// -----------------------------------------------------------------------------
module icosphere_edge_subdivider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  ies_pkg::ies_in_t              in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output ies_pkg::ies_out_t             out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ies_pkg::RAD_W-1:0]     cfg_data
);
	import ies_pkg::*;

	ies_top_st_t st_q, st_d;

	ies_in_t          item_q;
	logic [1:0]       edge_q;
	logic [1:0]       tri_q;
	logic [IDX_W-1:0] res_q [3];
	logic [CNT_W-1:0] vcount_q;
	logic [RAD_W-1:0] radius_q;
	ies_vtx_t         p_q, q_q;
	ies_vtx_t         vmem [VTX_DEPTH];
	ies_vtx_t         vrd_q;
	logic             out_valid_q;
	ies_out_t         out_q;

	logic [IDX_W-1:0] cp, cq, key_lo, key_hi;
	logic             out_free, vfull, in_xfer;
	logic             out_load, vwr, vcnt_inc, norm_start, norm_done;
	ies_out_t         out_next;
	logic [IDX_W-1:0] vaddr;
	ies_vtx_t         vwdata, mid, zero_vtx;
	ies_et_cmd_t      et_cmd;
	ies_et_stat_t     et_stat;
	logic [IDX_W-1:0] et_vid;
	logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;

	assign zero_vtx  = '0;
	assign in_ready  = (st_q == T_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign vfull     = (vcount_q >= CNT_W'(VTX_DEPTH));
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// corners of the current edge
	always_comb begin
		unique case (edge_q)
			2'd0: begin
				cp = item_q.first_corner;
				cq = item_q.second_corner;
			end
			2'd1: begin
				cp = item_q.second_corner;
				cq = item_q.third_corner;
			end
			default: begin
				cp = item_q.third_corner;
				cq = item_q.first_corner;
			end
		endcase
	end
	assign key_lo = (cp < cq) ? cp : cq;
	assign key_hi = (cp < cq) ? cq : cp;

	// corner sums for the midpoint direction
	assign sum_x = SUM_W'(p_q.x) + SUM_W'(q_q.x);
	assign sum_y = SUM_W'(p_q.y) + SUM_W'(q_q.y);
	assign sum_z = SUM_W'(p_q.z) + SUM_W'(q_q.z);

	ies_edge_tab u_edge_tab (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (et_cmd),
		.key_lo  (key_lo),
		.key_hi  (key_hi),
		.ins_vid (vcount_q[IDX_W-1:0]),
		.stat    (et_stat),
		.vid     (et_vid)
	);

	ies_norm_unit u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start),
		.sum_x  (sum_x),
		.sum_y  (sum_y),
		.sum_z  (sum_z),
		.radius (radius_q),
		.done   (norm_done),
		.pos_x  (mid.x),
		.pos_y  (mid.y),
		.pos_z  (mid.z)
	);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			T_IDLE: begin
				if (in_xfer) begin
					if (in_data.kind == KIND_LOAD)
						st_d = T_LOAD;
					else if (in_data.kind == KIND_SUBDIV)
						st_d = T_SEARCH_GO;
				end
			end
			T_LOAD:        if (out_free) st_d = T_IDLE;
			T_SEARCH_GO:   st_d = T_SEARCH_WAIT;
			T_SEARCH_WAIT: begin
				if (et_stat.done) begin
					if (et_stat.hit)
						st_d = (edge_q == 2'd2) ? T_TRI : T_SEARCH_GO;
					else if (et_stat.full || vfull)
						st_d = T_ERR;
					else
						st_d = T_RD_P;
				end
			end
			T_RD_P:        st_d = T_RD_Q;
			T_RD_Q:        st_d = T_RD_W;
			T_RD_W:        st_d = T_NORM_GO;
			T_NORM_GO:     st_d = T_NORM_WAIT;
			T_NORM_WAIT:   if (norm_done) st_d = T_VTX;
			T_VTX: begin
				if (out_free)
					st_d = (edge_q == 2'd2) ? T_TRI : T_SEARCH_GO;
			end
			T_ERR:         if (out_free) st_d = T_IDLE;
			T_TRI:         if (out_free && tri_q == 2'd3) st_d = T_IDLE;
			default:       st_d = T_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		out_load   = 1'b0;
		out_next   = '0;
		vwr        = 1'b0;
		vaddr      = cp;
		vwdata     = mid;
		et_cmd     = '0;
		norm_start = 1'b0;
		vcnt_inc   = 1'b0;
		unique case (st_q)
			T_IDLE: begin
				if (in_xfer && in_data.kind == KIND_CLEAR)
					et_cmd.clear = 1'b1;
			end
			T_LOAD: begin
				if (out_free) begin
					out_load      = 1'b1;
					out_next.last = 1'b1;
					if (vfull) begin
						out_next.store_full = 1'b1;
					end else begin
						out_next.index_a = vcount_q[IDX_W-1:0];
						out_next.pos_x   = item_q.load_x;
						out_next.pos_y   = item_q.load_y;
						out_next.pos_z   = item_q.load_z;
						vwr              = 1'b1;
						vaddr            = vcount_q[IDX_W-1:0];
						vwdata           = '{x: item_q.load_x, y: item_q.load_y,
							z: item_q.load_z};
						vcnt_inc         = 1'b1;
					end
				end
			end
			T_SEARCH_GO: et_cmd.start = 1'b1;
			T_RD_P:      vaddr = cp;
			T_RD_Q:      vaddr = cq;
			T_NORM_GO:   norm_start = 1'b1;
			T_VTX: begin
				if (out_free) begin
					out_load         = 1'b1;
					out_next.index_a = vcount_q[IDX_W-1:0];
					out_next.pos_x   = mid.x;
					out_next.pos_y   = mid.y;
					out_next.pos_z   = mid.z;
					vwr              = 1'b1;
					vaddr            = vcount_q[IDX_W-1:0];
					et_cmd.insert    = 1'b1;
					vcnt_inc         = 1'b1;
				end
			end
			T_ERR: begin
				if (out_free) begin
					out_load            = 1'b1;
					out_next.store_full = 1'b1;
					out_next.last       = 1'b1;
				end
			end
			T_TRI: begin
				if (out_free) begin
					out_load           = 1'b1;
					out_next.item_type = 1'b1;
					out_next.last      = (tri_q == 2'd3);
					unique case (tri_q)
						2'd0: begin
							out_next.index_a = item_q.first_corner;
							out_next.index_b = res_q[0];
							out_next.index_c = res_q[2];
						end
						2'd1: begin
							out_next.index_a = item_q.second_corner;
							out_next.index_b = res_q[1];
							out_next.index_c = res_q[0];
						end
						2'd2: begin
							out_next.index_a = item_q.third_corner;
							out_next.index_b = res_q[2];
							out_next.index_c = res_q[1];
						end
						default: begin
							out_next.index_a = res_q[0];
							out_next.index_b = res_q[1];
							out_next.index_c = res_q[2];
						end
					endcase
				end
			end
			default: ;
		endcase
	end

	// vertex store, one port, registered read
	always_ff @(posedge clk) begin
		if (vwr)
			vmem[vaddr] <= vwdata;
		vrd_q <= vmem[vaddr];
	end

	// corner capture, unloaded corners read as the origin
	always_ff @(posedge clk) begin
		if (st_q == T_RD_Q)
			p_q <= ({1'b0, cp} < vcount_q) ? vrd_q : zero_vtx;
		if (st_q == T_RD_W)
			q_q <= ({1'b0, cq} < vcount_q) ? vrd_q : zero_vtx;
		if (in_xfer)
			item_q <= in_data;
		if (st_q == T_SEARCH_WAIT && et_stat.done && et_stat.hit)
			res_q[edge_q] <= et_vid;
		if (st_q == T_VTX && out_free)
			res_q[edge_q] <= vcount_q[IDX_W-1:0];
		if (out_load)
			out_q <= out_next;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= T_IDLE;
			edge_q      <= '0;
			tri_q       <= '0;
			vcount_q    <= '0;
			radius_q    <= RAD_RESET;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_valid && cfg_ready)
				radius_q <= cfg_data;
			if (in_xfer) begin
				edge_q <= '0;
				tri_q  <= '0;
				if (in_data.kind == KIND_CLEAR)
					vcount_q <= '0;
			end
			if (vcnt_inc)
				vcount_q <= vcount_q + CNT_W'(1);
			// edge done on a hit or once its new vertex is sent
			if ((st_q == T_SEARCH_WAIT && et_stat.done && et_stat.hit) ||
				(st_q == T_VTX && out_free))
				edge_q <= edge_q + 2'd1;
			if (st_q == T_TRI && out_free)
				tri_q <= tri_q + 2'd1;
			// output register
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== sv/ies_checker.sv =====
// -----------------------------------------------------------------------------
// ies_checker
// Port-level checks on the subdivider, attached by bind
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module ies_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input ies_pkg::ies_in_t          in_data,
	input logic                      out_valid,
	input logic                      out_ready,
	input ies_pkg::ies_out_t         out_data
);
	import ies_pkg::*;

	logic in_stall, out_stall, full_ok, tri_pos_zero;

	assign in_stall     = in_valid && !in_ready;
	assign out_stall    = out_valid && !out_ready;
	assign full_ok      = out_data.last && !out_data.item_type;
	assign tri_pos_zero = (out_data.pos_x == 16'sd0) && (out_data.pos_y == 16'sd0) &&
		(out_data.pos_z == 16'sd0);

	// a waiting item holds
	`IES_ASSERT_NEXT(a_in_hold, clk, arst_n, in_stall, in_valid && $stable(in_data))

	// a stalled result holds
	`IES_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, out_valid && $stable(out_data))

	// an overflow record closes the item and is no triangle
	`IES_ASSERT_IMP(a_full_last, clk, arst_n, out_valid && out_data.store_full, full_ok)

	// triangle records carry no position
	`IES_ASSERT_IMP(a_tri_nopos, clk, arst_n, out_valid && out_data.item_type, tri_pos_zero)

	// mid-item results mean the block is still busy
	`IES_ASSERT_IMP(a_busy, clk, arst_n, out_valid && !out_data.last, !in_ready)

endmodule

bind icosphere_edge_subdivider ies_checker u_ies_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
